// File: src/range_add_undo_redo_engine_top_defines.svh
// Assertion macros for the range add engine.
`ifndef RANGE_ADD_UNDO_REDO_ENGINE_TOP_DEFINES_SVH
`define RANGE_ADD_UNDO_REDO_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTH
`define RAUR_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define RAUR_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RAUR_ASSERT_IMP(name, clk, rst, ante, cons)
`define RAUR_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

// File: src/raur_pkg.sv
package raur_pkg;

   localparam int unsigned OP_W   = 3;
   localparam int unsigned IDX_W  = 10;
   localparam int unsigned AMT_W  = 32;
   localparam int unsigned VAL_W  = 64;
   localparam int unsigned STAT_W = 2;
   localparam int unsigned ACT_W  = 11;

   localparam logic [ACT_W-1:0] ACTIVE_RESET = 11'd1024;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE = 3'd0,
      OP_ADD   = 3'd1,
      OP_SUB   = 3'd2,
      OP_UNDO  = 3'd3,
      OP_REDO  = 3'd4,
      OP_READ  = 3'd5
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      RS_DONE  = 2'd0,
      RS_EMPTY = 2'd1,
      RS_RANGE = 2'd2,
      RS_FULL  = 2'd3
   } status_type;

   // history slot: bit 0 subtract, then first, last, amount
   typedef struct packed {
      logic [AMT_W-1:0] amount;
      logic [IDX_W-1:0] last_index;
      logic [IDX_W-1:0] first_index;
      logic             sub;
   } rec_type;

   typedef enum logic [2:0] {
      CS_CLEAR,
      CS_IDLE,
      CS_DECODE,
      CS_READ_WAIT,
      CS_HIST_WAIT,
      CS_SWEEP,
      CS_FINISH
   } ctl_state_type;

   typedef struct packed {
      logic       clear_step;
      logic       load_req;
      logic       table_write;
      logic       table_read;
      logic       push_rec;
      logic       undo_fetch;
      logic       redo_fetch;
      logic       undo_commit;
      logic       redo_commit;
      logic       status_load;
      status_type status_code;
      logic       out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic   clear_last;
      op_type op;
      logic   bad_first;
      logic   bad_last;
      logic   hist_full;
      logic   undo_empty;
      logic   redo_empty;
      logic   sweep_busy;
      logic   out_free;
   } dp_stat_type;

endpackage

// File: src/raur_ctl.sv
`include "range_add_undo_redo_engine_top_defines.svh"

module raur_ctl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  raur_pkg::dp_stat_type stat,
   output raur_pkg::dp_cmd_type  cmd
);

   raur_pkg::ctl_state_type state_ff;
   raur_pkg::ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= raur_pkg::CS_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         raur_pkg::CS_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = raur_pkg::CS_IDLE;
            end
         end
         raur_pkg::CS_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = raur_pkg::CS_DECODE;
            end
         end
         raur_pkg::CS_DECODE: begin
            cmd.status_load = 1'b1;
            cmd.status_code = raur_pkg::RS_DONE;
            state_in        = raur_pkg::CS_FINISH;
            unique case (stat.op)
               raur_pkg::OP_WRITE: begin
                  if (stat.bad_first) begin
                     cmd.status_code = raur_pkg::RS_RANGE;
                  end else begin
                     cmd.table_write = 1'b1;
                  end
               end
               raur_pkg::OP_READ: begin
                  if (stat.bad_first) begin
                     cmd.status_code = raur_pkg::RS_RANGE;
                  end else begin
                     cmd.table_read = 1'b1;
                     state_in       = raur_pkg::CS_READ_WAIT;
                  end
               end
               raur_pkg::OP_ADD, raur_pkg::OP_SUB: begin
                  if (stat.bad_first || stat.bad_last) begin
                     cmd.status_code = raur_pkg::RS_RANGE;
                  end else if (stat.hist_full) begin
                     cmd.status_code = raur_pkg::RS_FULL;
                  end else begin
                     cmd.push_rec = 1'b1;
                     state_in     = raur_pkg::CS_SWEEP;
                  end
               end
               raur_pkg::OP_UNDO: begin
                  if (stat.undo_empty) begin
                     cmd.status_code = raur_pkg::RS_EMPTY;
                  end else begin
                     cmd.undo_fetch = 1'b1;
                     state_in       = raur_pkg::CS_HIST_WAIT;
                  end
               end
               raur_pkg::OP_REDO: begin
                  if (stat.redo_empty) begin
                     cmd.status_code = raur_pkg::RS_EMPTY;
                  end else begin
                     cmd.redo_fetch = 1'b1;
                     state_in       = raur_pkg::CS_HIST_WAIT;
                  end
               end
               default: begin
               end
            endcase
         end
         raur_pkg::CS_READ_WAIT: begin
            state_in = raur_pkg::CS_FINISH;
         end
         raur_pkg::CS_HIST_WAIT: begin
            if (stat.op == raur_pkg::OP_UNDO) begin
               cmd.undo_commit = 1'b1;
            end else begin
               cmd.redo_commit = 1'b1;
            end
            state_in = raur_pkg::CS_SWEEP;
         end
         raur_pkg::CS_SWEEP: begin
            if (!stat.sweep_busy) begin
               state_in = raur_pkg::CS_FINISH;
            end
         end
         raur_pkg::CS_FINISH: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = raur_pkg::CS_IDLE;
            end
         end
         default: begin
            state_in = raur_pkg::CS_IDLE;
         end
      endcase
   end

   `RAUR_ASSERT_NXT(a_sweep_entry, clock, reset, cmd.push_rec || cmd.undo_commit || cmd.redo_commit, state_ff == raur_pkg::CS_SWEEP)
   `RAUR_ASSERT_NXT(a_accept_decode, clock, reset, req_tvalid && req_tready, state_ff == raur_pkg::CS_DECODE)

endmodule

// File: src/raur_dp.sv
`include "range_add_undo_redo_engine_top_defines.svh"

module raur_dp #(
   parameter int unsigned TABLE_DEPTH   = 1024,
   parameter int unsigned HISTORY_DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  raur_pkg::dp_cmd_type                cmd,
   output raur_pkg::dp_stat_type               stat,
   input  logic [raur_pkg::OP_W-1:0]           req_operation,
   input  logic [raur_pkg::IDX_W-1:0]          req_first_index,
   input  logic [raur_pkg::IDX_W-1:0]          req_last_index,
   input  logic signed [raur_pkg::AMT_W-1:0]   req_amount,
   input  logic signed [raur_pkg::VAL_W-1:0]   req_entry_value,
   input  logic                                csr_wr_en,
   input  logic [raur_pkg::ACT_W-1:0]          csr_wr_data,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic signed [raur_pkg::VAL_W-1:0]   rsp_read_value,
   output logic [raur_pkg::STAT_W-1:0]         rsp_status
);

   localparam int unsigned IDX_W    = raur_pkg::IDX_W;
   localparam int unsigned VAL_W    = raur_pkg::VAL_W;
   localparam int unsigned AMT_W    = raur_pkg::AMT_W;
   localparam int unsigned TABLE_AW = $clog2(TABLE_DEPTH);
   localparam int unsigned XW       = (TABLE_AW > IDX_W) ? TABLE_AW : IDX_W;
   localparam int unsigned HIST_AW  = $clog2(HISTORY_DEPTH);
   localparam int unsigned DEPTH_W  = $clog2(HISTORY_DEPTH + 1);
   localparam logic [DEPTH_W:0]      HIST_FULL = (DEPTH_W + 1)'(HISTORY_DEPTH);
   localparam logic [DEPTH_W-1:0]    HIST_TOP  = DEPTH_W'(HISTORY_DEPTH);
   localparam logic [DEPTH_W-1:0]    HIST_LAST = DEPTH_W'(HISTORY_DEPTH - 1);
   localparam logic [TABLE_AW-1:0]   CLR_LAST  = TABLE_AW'(TABLE_DEPTH - 1);

   logic [VAL_W-1:0]          table_mem [TABLE_DEPTH];
   raur_pkg::rec_type         history_mem [HISTORY_DEPTH];

   // request
   raur_pkg::op_type          op_ff;
   logic [IDX_W-1:0]          first_ff;
   logic [IDX_W-1:0]          last_ff;
   logic [AMT_W-1:0]          amount_ff;
   logic [VAL_W-1:0]          value_ff;

   logic [raur_pkg::ACT_W-1:0] active_ff, active_in;
   logic [TABLE_AW-1:0]       clr_idx_ff, clr_idx_in;
   logic [DEPTH_W-1:0]        undo_ff, undo_in;
   logic [DEPTH_W-1:0]        redo_ff, redo_in;

   // sweep engine
   logic                      sweep_on_ff, sweep_on_in;
   logic [IDX_W:0]            sweep_idx_ff, sweep_idx_in;
   logic [IDX_W-1:0]          sweep_hi_ff, sweep_hi_in;
   logic [VAL_W-1:0]          sweep_delta_ff, sweep_delta_in;
   logic                      wr_pend_ff, wr_pend_in;
   logic [TABLE_AW-1:0]       wr_addr_ff, wr_addr_in;

   logic                      res_read_ff, res_read_in;
   raur_pkg::status_type      res_status_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]          rsp_value_ff;
   logic [raur_pkg::STAT_W-1:0] rsp_status_ff;

   logic [VAL_W-1:0]          table_rd_ff;
   raur_pkg::rec_type         hist_rd_ff;

   logic [XW-1:0]             first_x;
   logic [XW-1:0]             sweep_x;
   logic [TABLE_AW-1:0]       first_addr;
   logic [TABLE_AW-1:0]       sweep_addr;
   logic                      sweep_act;
   logic                      sweep_start;
   logic [DEPTH_W:0]          depth_sum;
   logic                      out_free;

   logic                      tbl_we, tbl_re;
   logic [TABLE_AW-1:0]       tbl_waddr, tbl_raddr;
   logic [VAL_W-1:0]          tbl_wdata;
   logic                      hist_we, hist_re;
   logic [HIST_AW-1:0]        hist_waddr, hist_raddr;
   raur_pkg::rec_type         hist_wdata;
   raur_pkg::rec_type         new_rec;

   logic [IDX_W-1:0]          start_lo, start_hi;
   logic [AMT_W-1:0]          start_amt;
   logic                      start_neg;
   logic [VAL_W-1:0]          start_ext;

   assign first_x    = XW'(first_ff);
   assign first_addr = first_x[TABLE_AW-1:0];
   assign sweep_x    = XW'(sweep_idx_ff);
   assign sweep_addr = sweep_x[TABLE_AW-1:0];
   assign sweep_act  = sweep_on_ff && (sweep_idx_ff <= {1'b0, sweep_hi_ff})
                       && (32'(sweep_idx_ff) < TABLE_DEPTH);
   assign sweep_start = cmd.push_rec || cmd.undo_commit || cmd.redo_commit;
   assign depth_sum  = {1'b0, undo_ff} + {1'b0, redo_ff};
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign new_rec.sub         = (op_ff == raur_pkg::OP_SUB);
   assign new_rec.first_index = first_ff;
   assign new_rec.last_index  = last_ff;
   assign new_rec.amount      = amount_ff;

   always_comb begin
      stat.clear_last = (clr_idx_ff == CLR_LAST);
      stat.op         = op_ff;
      stat.bad_first  = ({1'b0, first_ff} >= active_ff) || (32'(first_ff) >= TABLE_DEPTH);
      stat.bad_last   = ({1'b0, last_ff} >= active_ff) || (32'(last_ff) >= TABLE_DEPTH);
      stat.hist_full  = (depth_sum >= HIST_FULL);
      stat.undo_empty = (undo_ff == '0);
      stat.redo_empty = (redo_ff == '0);
      stat.sweep_busy = sweep_on_ff || wr_pend_ff;
      stat.out_free   = out_free;
   end

   // sweep start values
   always_comb begin
      if (cmd.push_rec) begin
         start_lo  = first_ff;
         start_hi  = last_ff;
         start_amt = amount_ff;
         start_neg = (op_ff == raur_pkg::OP_SUB);
      end else begin
         start_lo  = hist_rd_ff.first_index;
         start_hi  = hist_rd_ff.last_index;
         start_amt = hist_rd_ff.amount;
         start_neg = hist_rd_ff.sub ^ cmd.undo_commit;
      end
      start_ext = {{(VAL_W - AMT_W){start_amt[AMT_W-1]}}, start_amt};
   end

   always_comb begin
      sweep_on_in    = sweep_on_ff;
      sweep_idx_in   = sweep_idx_ff;
      sweep_hi_in    = sweep_hi_ff;
      sweep_delta_in = sweep_delta_ff;
      wr_pend_in     = sweep_act;
      wr_addr_in     = sweep_addr;
      if (sweep_start) begin
         sweep_on_in    = 1'b1;
         sweep_idx_in   = {1'b0, start_lo};
         sweep_hi_in    = start_hi;
         sweep_delta_in = start_neg ? (~start_ext + VAL_W'(1)) : start_ext;
      end else if (sweep_act) begin
         sweep_idx_in = sweep_idx_ff + (IDX_W + 1)'(1);
      end else begin
         sweep_on_in = 1'b0;
      end
   end

   // table ports
   always_comb begin
      tbl_we    = 1'b0;
      tbl_waddr = first_addr;
      tbl_wdata = value_ff;
      if (cmd.clear_step) begin
         tbl_we    = 1'b1;
         tbl_waddr = clr_idx_ff;
         tbl_wdata = '0;
      end else if (cmd.table_write) begin
         tbl_we = 1'b1;
      end else if (wr_pend_ff) begin
         tbl_we    = 1'b1;
         tbl_waddr = wr_addr_ff;
         tbl_wdata = table_rd_ff + sweep_delta_ff;
      end
      tbl_re    = cmd.table_read || sweep_act;
      tbl_raddr = sweep_act ? sweep_addr : first_addr;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         table_mem[tbl_waddr] <= tbl_wdata;
      end
      if (tbl_re) begin
         table_rd_ff <= table_mem[tbl_raddr];
      end
   end

   // history ports: undo grows up from slot 0, redo down from the top slot
   always_comb begin
      hist_we    = cmd.push_rec || cmd.undo_commit || cmd.redo_commit;
      hist_wdata = cmd.push_rec ? new_rec : hist_rd_ff;
      hist_waddr = cmd.undo_commit ? HIST_AW'(HIST_LAST - redo_ff) : HIST_AW'(undo_ff);
      hist_re    = cmd.undo_fetch || cmd.redo_fetch;
      hist_raddr = cmd.undo_fetch ? HIST_AW'(undo_ff - DEPTH_W'(1))
                                  : HIST_AW'(HIST_TOP - redo_ff);
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         history_mem[hist_waddr] <= hist_wdata;
      end
      if (hist_re) begin
         hist_rd_ff <= history_mem[hist_raddr];
      end
   end

   always_comb begin
      active_in  = csr_wr_en ? csr_wr_data : active_ff;
      clr_idx_in = cmd.clear_step ? clr_idx_ff + TABLE_AW'(1) : clr_idx_ff;
      undo_in    = undo_ff;
      redo_in    = redo_ff;
      if (cmd.push_rec || cmd.redo_commit) begin
         undo_in = undo_ff + DEPTH_W'(1);
      end else if (cmd.undo_fetch) begin
         undo_in = undo_ff - DEPTH_W'(1);
      end
      if (cmd.undo_commit) begin
         redo_in = redo_ff + DEPTH_W'(1);
      end else if (cmd.redo_fetch) begin
         redo_in = redo_ff - DEPTH_W'(1);
      end
      res_read_in = res_read_ff;
      if (cmd.load_req) begin
         res_read_in = 1'b0;
      end else if (cmd.table_read) begin
         res_read_in = 1'b1;
      end
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= raur_pkg::ACTIVE_RESET;
         clr_idx_ff   <= '0;
         undo_ff      <= '0;
         redo_ff      <= '0;
         sweep_on_ff  <= 1'b0;
         wr_pend_ff   <= 1'b0;
         res_read_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         clr_idx_ff   <= clr_idx_in;
         undo_ff      <= undo_in;
         redo_ff      <= redo_in;
         sweep_on_ff  <= sweep_on_in;
         wr_pend_ff   <= wr_pend_in;
         res_read_ff  <= res_read_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sweep_idx_ff   <= sweep_idx_in;
      sweep_hi_ff    <= sweep_hi_in;
      sweep_delta_ff <= sweep_delta_in;
      wr_addr_ff     <= wr_addr_in;
      if (cmd.load_req) begin
         op_ff     <= raur_pkg::op_type'(req_operation);
         first_ff  <= req_first_index;
         last_ff   <= req_last_index;
         amount_ff <= req_amount;
         value_ff  <= req_entry_value;
      end
      if (cmd.status_load) begin
         res_status_ff <= cmd.status_code;
      end
      if (cmd.out_load) begin
         rsp_value_ff  <= res_read_ff ? table_rd_ff : '0;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;

   `RAUR_ASSERT_IMP(a_hist_bound, clock, reset, 1'b1, depth_sum <= HIST_FULL)
   `RAUR_ASSERT_IMP(a_out_free, clock, reset, cmd.out_load, out_free)
   `RAUR_ASSERT_IMP(a_clear_quiet, clock, reset, cmd.clear_step, !stat.sweep_busy)

endmodule

// File: src/range_add_undo_redo_engine_top.sv
// Range add engine with undo/redo over a table of TABLE_DEPTH signed 64-bit entries and a
// history of HISTORY_DEPTH range operations. After reset the table is zeroed by a clearing
// pass over every entry, during which req_tready stays low; csr writes are taken at any
// time. One transaction is in work at a time and each gives one response. The sweep of
// an add, subtract, undo or redo does one table read-modify-write per cycle through the
// single table write port. A response waiting in the output register does not block the
// next request.
module range_add_undo_redo_engine_top #(
   parameter int unsigned TABLE_DEPTH   = 1024,
   parameter int unsigned HISTORY_DEPTH = 256
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [119:0]  req_tdata,   // first_index[9:0], last_index[19:10], amount[51:20],
                                      // entry_value[115:52], zero pad
   input  logic [2:0]    req_tuser,   // operation[2:0]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [63:0]   rsp_tdata,   // read_value[63:0]
   output logic [1:0]    rsp_tuser,   // status[1:0]
   input  logic          csr_wr_en,
   input  logic [10:0]   csr_wr_data  // active_entries
);

   raur_pkg::dp_cmd_type  cmd;
   raur_pkg::dp_stat_type stat;
   logic signed [raur_pkg::VAL_W-1:0] read_value;

   raur_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   raur_dp #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_operation   (req_tuser),
      .req_first_index (req_tdata[9:0]),
      .req_last_index  (req_tdata[19:10]),
      .req_amount      (req_tdata[51:20]),
      .req_entry_value (req_tdata[115:52]),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_read_value  (read_value),
      .rsp_status      (rsp_tuser)
   );

   assign rsp_tdata = read_value;

endmodule
